[rtl/phd_pkg.sv]
package phd_pkg;

   localparam int CHANNELS = 4;
   localparam int WINDOW   = 8;
   localparam int CH_W     = $clog2(CHANNELS);
   localparam int WIN_W    = $clog2(WINDOW);
   localparam int ADDR_W   = CH_W + WIN_W;
   localparam int WIN_DEPTH = CHANNELS * WINDOW;

   localparam int SAMPLE_W = 16;
   localparam int THR_W    = 16;
   localparam int COOL_W   = 16;
   localparam int TIME_W   = 32;
   localparam int SETV_W   = 7;
   localparam int HP_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [HP_W-1:0] HP_FLOOR = -8'sd10;
   localparam logic [THR_W-1:0]  RESET_THRESHOLD = 16'd2000;
   localparam logic [COOL_W-1:0] RESET_COOLDOWN  = 16'd1000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESH0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN = 3'd5;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SET_HP = 1'b1;

   typedef struct packed {
      logic                       op;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic [TIME_W-1:0]          time_ms;
      logic [SETV_W-1:0]          set_value;
      logic [THR_W-1:0]           thr;
      logic [THR_W-1:0]           thr_half;
      logic                       enable;
      logic [COOL_W-1:0]          cooldown;
   } cmd_type;

   typedef struct packed {
      logic [CH_W-1:0]        out_channel;
      logic [THR_W-1:0]       swing;
      logic                   over_flag;
      logic                   hit;
      logic signed [HP_W-1:0] hitpoints;
      logic                   dead;
   } rsp_type;

endpackage

[rtl/piezo_hit_detector_top.sv]
// channel   direction  handshake        payload
// request   in         push / full      req_op, req_channel, req_sample, req_time_ms,
//                                       req_set_value
// response  out        empty / pop      rsp_out_channel, rsp_swing, rsp_over_flag,
//                                       rsp_hit, rsp_hitpoints, rsp_dead
// csr       in         csr_wr_en        csr_index, csr_wdata (write only)
//
// A sample word passes through the back end in order: a pop, a window RAM write, a walk of
// the 8 window entries through the single RAM read port, a subtract, and the decision.
// Set-hitpoints words go from pop to decision. Only one word is in the back end at a time.
// Two-word queues on each side let push and pop stall independently of the back end.
// Sync reset clears control and channel state; unwritten window entries read as zero.
module piezo_hit_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_op,
   input  logic [phd_pkg::CH_W-1:0]            req_channel,
   input  logic signed [phd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [phd_pkg::TIME_W-1:0]          req_time_ms,
   input  logic [phd_pkg::SETV_W-1:0]          req_set_value,
   output logic                                empty,
   input  logic                                pop,
   output logic [phd_pkg::CH_W-1:0]            rsp_out_channel,
   output logic [phd_pkg::THR_W-1:0]           rsp_swing,
   output logic                                rsp_over_flag,
   output logic                                rsp_hit,
   output logic signed [phd_pkg::HP_W-1:0]     rsp_hitpoints,
   output logic                                rsp_dead,
   input  logic                                csr_wr_en,
   input  logic [phd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [phd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic             cmd_valid, cmd_pop;
   phd_pkg::cmd_type cmd;
   logic             rsp_full, rsp_push;
   phd_pkg::rsp_type rsp, rsp_head;

   phd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_channel   (req_channel),
      .req_sample    (req_sample),
      .req_time_ms   (req_time_ms),
      .req_set_value (req_set_value),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .cmd           (cmd)
   );

   phd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   phd_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp      (rsp),
      .rsp_full (rsp_full),
      .pop      (pop),
      .empty    (empty),
      .rsp_head (rsp_head)
   );

   assign rsp_out_channel  = rsp_head.out_channel;
   assign rsp_swing        = rsp_head.swing;
   assign rsp_over_flag    = rsp_head.over_flag;
   assign rsp_hit          = rsp_head.hit;
   assign rsp_hitpoints    = rsp_head.hitpoints;
   assign rsp_dead         = rsp_head.dead;

endmodule

[rtl/phd_ram.sv]
module phd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/phd_front.sv]
module phd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic                                req_op,
   input  logic [phd_pkg::CH_W-1:0]            req_channel,
   input  logic signed [phd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [phd_pkg::TIME_W-1:0]          req_time_ms,
   input  logic [phd_pkg::SETV_W-1:0]          req_set_value,
   input  logic                                csr_wr_en,
   input  logic [phd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [phd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                cmd_valid,
   input  logic                                cmd_pop,
   output phd_pkg::cmd_type                    cmd
);

   localparam int PTR_W = $clog2(phd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(phd_pkg::QUEUE_DEPTH + 1);

   logic [phd_pkg::THR_W-1:0]    thr_ff [phd_pkg::CHANNELS];
   logic [phd_pkg::THR_W-1:0]    thr_in [phd_pkg::CHANNELS];
   logic [phd_pkg::CHANNELS-1:0] en_ff, en_in;
   logic [phd_pkg::COOL_W-1:0]   cool_ff, cool_in;

   phd_pkg::cmd_type q_ff [phd_pkg::QUEUE_DEPTH];
   phd_pkg::cmd_type new_cmd;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept, take;

   // register writes
   always_comb begin
      thr_in  = thr_ff;
      en_in   = en_ff;
      cool_in = cool_ff;
      if (csr_wr_en) begin
         case (csr_index)
            phd_pkg::REG_THRESH0,
            phd_pkg::REG_THRESH1,
            phd_pkg::REG_THRESH2,
            phd_pkg::REG_THRESH3: begin
               thr_in[csr_index[phd_pkg::CH_W-1:0]] = csr_wdata[phd_pkg::THR_W-1:0];
            end
            phd_pkg::REG_ENABLE: begin
               en_in = csr_wdata[phd_pkg::CHANNELS-1:0];
            end
            phd_pkg::REG_COOLDOWN: begin
               cool_in = csr_wdata[phd_pkg::COOL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < phd_pkg::CHANNELS; i++) begin
            thr_ff[i] <= phd_pkg::RESET_THRESHOLD;
         end
         en_ff   <= '0;
         cool_ff <= phd_pkg::RESET_COOLDOWN;
      end else begin
         thr_ff  <= thr_in;
         en_ff   <= en_in;
         cool_ff <= cool_in;
      end
   end

   // tag each word with its channel's threshold and enable and the shared cooldown
   always_comb begin
      new_cmd.op        = req_op;
      new_cmd.channel   = req_channel;
      new_cmd.sample    = req_sample;
      new_cmd.time_ms   = req_time_ms;
      new_cmd.set_value = req_set_value;
      new_cmd.thr       = thr_ff[req_channel];
      new_cmd.thr_half  = thr_ff[req_channel] >> 1;
      new_cmd.enable    = en_ff[req_channel];
      new_cmd.cooldown  = cool_ff;
   end

   assign full      = (cnt_ff == CNT_W'(phd_pkg::QUEUE_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !accept) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

[rtl/phd_core.sv]
module phd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  phd_pkg::cmd_type cmd,
   input  logic             rsp_full,
   output logic             rsp_push,
   output phd_pkg::rsp_type rsp
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam int CH   = phd_pkg::CHANNELS;
   localparam int SW   = phd_pkg::SAMPLE_W;
   localparam int TW   = phd_pkg::TIME_W;
   localparam int HW   = phd_pkg::HP_W;
   localparam int AW   = phd_pkg::ADDR_W;
   localparam int WW   = phd_pkg::WIN_W;
   localparam int IDXW = WW + 1;

   logic [2:0] state_ff, state_in;
   phd_pkg::cmd_type cmd_ff, cmd_in;

   logic [WW-1:0]          wp_ff       [CH];
   logic [WW-1:0]          wp_in       [CH];
   logic [CH-1:0]          over_ff, over_in;
   logic [TW-1:0]          last_time_ff [CH];
   logic [TW-1:0]          last_time_in [CH];
   logic [CH-1:0]          last_vld_ff, last_vld_in;
   logic signed [HW-1:0]   hp_ff       [CH];
   logic signed [HW-1:0]   hp_in       [CH];
   logic [phd_pkg::WIN_DEPTH-1:0] win_vld_ff, win_vld_in;

   logic [IDXW-1:0]        rd_idx_ff, rd_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   ent_vld_ff, ent_vld_in;
   logic                   first_ff, first_in;
   logic signed [SW-1:0]   min_ff, min_in, max_ff, max_in;
   logic [TW-1:0]          limit_ff, limit_in;
   logic [phd_pkg::THR_W-1:0] ptp_ff, ptp_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [SW-1:0]          ram_rd_data;
   logic signed [SW-1:0]   rd_val;
   logic signed [SW:0]     diff;
   logic [CH-1:0]          ch_dec;

   logic                   ge_thr, lt_half, rise, hit;
   logic signed [HW-1:0]   hp_cur, hp_dec, hp_new;
   logic                   over_new, dead;

   phd_ram #(
      .WIDTH (SW),
      .DEPTH (phd_pkg::WIN_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cmd_ff.sample),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_addr = {cmd_ff.channel, wp_ff[cmd_ff.channel]};
   assign ram_rd_addr = {cmd_ff.channel, rd_idx_ff[WW-1:0]};
   // never-written entries read as zero
   assign rd_val      = ent_vld_ff ? $signed(ram_rd_data) : '0;
   assign diff        = {max_ff[SW-1], max_ff} - {min_ff[SW-1], min_ff};
   assign ch_dec      = CH'(1) << cmd_ff.channel;

   // decision for the final step
   always_comb begin
      hp_cur   = hp_ff[cmd_ff.channel];
      hp_dec   = hp_cur - HW'(1);
      ge_thr   = (ptp_ff >= cmd_ff.thr);
      lt_half  = (ptp_ff < cmd_ff.thr_half);
      rise     = (cmd_ff.op == phd_pkg::OP_SAMPLE) && ge_thr && !over_ff[cmd_ff.channel];
      hit      = rise && cmd_ff.enable &&
                 (!last_vld_ff[cmd_ff.channel] || (cmd_ff.time_ms > limit_ff));
      over_new = over_ff[cmd_ff.channel];
      hp_new   = hp_cur;
      dead     = 1'b0;
      if (cmd_ff.op == phd_pkg::OP_SET_HP) begin
         hp_new = {1'b0, cmd_ff.set_value};
         dead   = (cmd_ff.set_value == '0);
      end else begin
         if (ge_thr) begin
            over_new = 1'b1;
         end else if (lt_half) begin
            over_new = 1'b0;
         end
         // hold at the floor, still counting the hit
         if (hit && (hp_cur > phd_pkg::HP_FLOOR)) begin
            hp_new = hp_dec;
            dead   = hp_dec[HW-1] || (hp_dec == '0);
         end
      end
      rsp.out_channel  = cmd_ff.channel;
      rsp.swing        = (cmd_ff.op == phd_pkg::OP_SAMPLE) ? ptp_ff : '0;
      rsp.over_flag    = over_new;
      rsp.hit          = hit;
      rsp.hitpoints    = hp_new;
      rsp.dead         = dead;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      wp_in        = wp_ff;
      over_in      = over_ff;
      last_time_in = last_time_ff;
      last_vld_in  = last_vld_ff;
      hp_in        = hp_ff;
      win_vld_in   = win_vld_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      ent_vld_in   = ent_vld_ff;
      first_in     = first_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      limit_in     = limit_ff;
      ptp_in       = ptp_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      // fold in the word read last cycle
      if (rd_pend_ff) begin
         first_in = 1'b0;
         if (first_ff || (rd_val < min_ff)) begin
            min_in = rd_val;
         end
         if (first_ff || (rd_val > max_ff)) begin
            max_in = rd_val;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = (cmd.op == phd_pkg::OP_SAMPLE) ? S_WRITE : S_DONE;
            end
         end
         S_WRITE: begin
            ram_wr_en                      = 1'b1;
            win_vld_in[ram_wr_addr]        = 1'b1;
            wp_in[cmd_ff.channel]          = wp_ff[cmd_ff.channel] + 1'b1;
            limit_in  = last_time_ff[cmd_ff.channel] + TW'(cmd_ff.cooldown);
            rd_idx_in = '0;
            first_in  = 1'b1;
            state_in  = S_WALK;
         end
         S_WALK: begin
            if (rd_idx_ff != IDXW'(phd_pkg::WINDOW)) begin
               ram_rd_en  = 1'b1;
               ent_vld_in = win_vld_ff[ram_rd_addr];
               rd_pend_in = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else if (rd_pend_ff) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ptp_in   = diff[SW-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_full) begin
               rsp_push                 = 1'b1;
               over_in                  = (over_ff & ~ch_dec) | (over_new ? ch_dec : '0);
               hp_in[cmd_ff.channel]    = hp_new;
               if (hit) begin
                  last_time_in[cmd_ff.channel] = cmd_ff.time_ms;
                  last_vld_in[cmd_ff.channel]  = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         over_ff     <= '0;
         last_vld_ff <= '0;
         win_vld_ff  <= '0;
         rd_pend_ff  <= 1'b0;
         for (int i = 0; i < CH; i++) begin
            wp_ff[i]        <= '0;
            last_time_ff[i] <= '0;
            hp_ff[i]        <= '0;
         end
      end else begin
         state_ff     <= state_in;
         over_ff      <= over_in;
         last_vld_ff  <= last_vld_in;
         win_vld_ff   <= win_vld_in;
         rd_pend_ff   <= rd_pend_in;
         wp_ff        <= wp_in;
         last_time_ff <= last_time_in;
         hp_ff        <= hp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rd_idx_ff  <= rd_idx_in;
      ent_vld_ff <= ent_vld_in;
      first_ff   <= first_in;
      min_ff     <= min_in;
      max_ff     <= max_in;
      limit_ff   <= limit_in;
      ptp_ff     <= ptp_in;
   end

endmodule

[rtl/phd_rsp_queue.sv]
module phd_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_push,
   input  phd_pkg::rsp_type rsp,
   output logic             rsp_full,
   input  logic             pop,
   output logic             empty,
   output phd_pkg::rsp_type rsp_head
);

   localparam int PTR_W = $clog2(phd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(phd_pkg::QUEUE_DEPTH + 1);

   phd_pkg::rsp_type q_ff [phd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             put, take;

   assign rsp_full = (cnt_ff == CNT_W'(phd_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign rsp_head = q_ff[rd_ptr_ff];
   assign put      = rsp_push && !rsp_full;
   assign take     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (put) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(phd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_ff + 1'b1;
      end
      if (put && !take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (take && !put) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         q_ff[wr_ptr_ff] <= rsp;
      end
   end

endmodule
